>>> rtl/core/nis_pkg.sv
package nis_pkg;

	// default longest Exp-Golomb prefix accepted before flagging overflow
	localparam int MAX_PREFIX_ZEROS_DEF = 31;

	localparam int CODE_W = 32;
	localparam int TYPE_W = 5;
	localparam int BYTE_W = 8;

	// NAL unit types of interest
	localparam logic [TYPE_W-1:0] TYPE_SLICE = 5'd1;
	localparam logic [TYPE_W-1:0] TYPE_IDR   = 5'd5;

	// slice_type residues mod 5 that mean intra
	localparam logic [2:0] KIND_I  = 3'd2;
	localparam logic [2:0] KIND_SI = 3'd4;

	// saturated byte count that a full slice header needs
	localparam logic [1:0] BYTE_COUNT_FULL = 2'd3;

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_MB_PREFIX = 3'd1,
		PH_MB_SUFFIX = 3'd2,
		PH_ST_PREFIX = 3'd3,
		PH_ST_SUFFIX = 3'd4,
		PH_DONE      = 3'd5,
		PH_IGNORE    = 3'd6
	} nis_phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_BITS,
		SQ_PAD,
		SQ_FINISH
	} nis_seq_t;

	// sequencer to bit unit
	typedef struct packed {
		logic              step;
		logic              bit_val;
		logic              final_bit;
		logic              load_header;
		logic              clear;
		logic [BYTE_W-1:0] header_byte;
	} nis_ctl_t;

	// bit unit to sequencer
	typedef struct packed {
		nis_phase_t        phase;
		logic [TYPE_W-1:0] header_type;
		logic              overflow;
		logic              slice_intra;
		logic [CODE_W-1:0] code_value;
	} nis_stat_t;

	// residue mod 5 of a value below 15
	function automatic logic [2:0] mod5_small(input logic [3:0] v);
		logic [3:0] r;
		if (v >= 4'd10) begin
			r = v - 4'd10;
		end else if (v >= 4'd5) begin
			r = v - 4'd5;
		end else begin
			r = v;
		end
		return r[2:0];
	endfunction

endpackage

>>> rtl/core/nis_in_if.sv
interface nis_in_if;
	logic                     valid;
	logic                     ready;
	logic [nis_pkg::BYTE_W-1:0] data_byte;
	logic                     last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/core/nis_out_if.sv
interface nis_out_if;
	logic                       valid;
	logic                       ready;
	logic [nis_pkg::TYPE_W-1:0] unit_type;
	logic                       is_intra;
	logic [nis_pkg::CODE_W-1:0] slice_kind;
	logic                       prefix_overflow;

	modport source (output valid, output unit_type, output is_intra, output slice_kind,
		output prefix_overflow, input ready);
	modport sink (input valid, input unit_type, input is_intra, input slice_kind,
		input prefix_overflow, output ready);
endinterface

>>> rtl/core/nal_intra_slice_detector.sv
// nal_intra_slice_detector: tells whether an H.264 NAL unit carries an intra slice
// nal_in carries the bytes of one NAL unit in order, header byte first, with
// last_byte set on the final byte; result carries one item per unit, given
// after the last byte: unit_type, is_intra, slice_kind and prefix_overflow
// both channels use valid/ready; an item moves on an edge with both high
// the header byte is loaded straight into the bit unit; a later byte is fed,
// one bit per cycle, through the shared bit unit while the two Exp-Golomb codes
// are still being parsed, and is dropped as it is taken once slice_type is known
// or the unit is ignored; after the last byte the unit pads any open code with
// zero bits, then loads the result register
// the result register parts the two sides: the next unit's bytes are taken
// while a result waits; if the receiver stalls, the block finishes the
// following unit and then takes no bytes until the register frees up
// reset (arst_n low) clears the parser to expect a header byte and drops any
// pending result
module nal_intra_slice_detector #(
	parameter int MAX_PREFIX_ZEROS = nis_pkg::MAX_PREFIX_ZEROS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	nis_in_if.sink    nal_in,
	nis_out_if.source result
);

	nis_pkg::nis_seq_t          state_q, state_d;
	nis_pkg::nis_ctl_t          ctl;
	nis_pkg::nis_stat_t         ust;

	logic [nis_pkg::BYTE_W-2:0] shift_q, shift_d;   // remaining bits of the byte
	logic [2:0]                 cnt_q, cnt_d;       // bits left after this one
	logic                       last_q, last_d;
	logic [1:0]                 byte_count_q, byte_count_d;

	logic                       out_valid_q;
	logic [nis_pkg::TYPE_W-1:0] out_type_q;
	logic                       out_intra_q;
	logic [nis_pkg::CODE_W-1:0] out_kind_q;
	logic                       out_ovf_q;

	logic                       accept;
	logic                       parsing;        // unit is inside a prefix or suffix
	logic                       load_out;
	logic                       full_len;
	logic                       slice_ok;
	logic                       res_intra;
	logic [nis_pkg::CODE_W-1:0] res_kind;
	logic                       res_ovf;

	nis_bit_unit #(
		.MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS)
	) u_bit_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.stat  (ust)
	);

	// bytes are taken only while the sequencer waits for one
	assign nal_in.ready = (state_q == nis_pkg::SQ_IDLE);
	assign accept  = nal_in.valid && nal_in.ready;
	assign parsing = (ust.phase == nis_pkg::PH_MB_PREFIX) ||
		(ust.phase == nis_pkg::PH_MB_SUFFIX) ||
		(ust.phase == nis_pkg::PH_ST_PREFIX) ||
		(ust.phase == nis_pkg::PH_ST_SUFFIX);

	// result fields from the finished parse
	assign full_len  = (byte_count_q == nis_pkg::BYTE_COUNT_FULL);
	assign slice_ok  = full_len && (ust.header_type == nis_pkg::TYPE_SLICE) &&
		!ust.overflow && (ust.phase == nis_pkg::PH_DONE);
	assign res_intra = full_len && ((ust.header_type == nis_pkg::TYPE_IDR) ||
		(slice_ok && ust.slice_intra));
	assign res_kind  = slice_ok ? ust.code_value : '0;
	assign res_ovf   = full_len && (ust.header_type == nis_pkg::TYPE_SLICE) && ust.overflow;

	// sequencer
	always_comb begin
		state_d          = state_q;
		shift_d          = shift_q;
		cnt_d            = cnt_q;
		last_d           = last_q;
		byte_count_d     = byte_count_q;
		ctl              = '0;
		ctl.header_byte  = nal_in.data_byte;
		load_out         = 1'b0;

		unique case (state_q)
			nis_pkg::SQ_IDLE: begin
				if (accept) begin
					last_d = nal_in.last_byte;
					if (ust.phase == nis_pkg::PH_HEADER) begin
						ctl.load_header = 1'b1;
						byte_count_d    = 2'd1;
						state_d         = nal_in.last_byte ? nis_pkg::SQ_PAD : nis_pkg::SQ_IDLE;
					end else begin
						if (byte_count_q != nis_pkg::BYTE_COUNT_FULL) begin
							byte_count_d = byte_count_q + 2'd1;
						end
						if (parsing) begin
							// msb goes in right away, the other seven follow
							ctl.step    = 1'b1;
							ctl.bit_val = nal_in.data_byte[nis_pkg::BYTE_W-1];
							shift_d     = nal_in.data_byte[nis_pkg::BYTE_W-2:0];
							cnt_d       = 3'(nis_pkg::BYTE_W - 2);
							state_d     = nis_pkg::SQ_BITS;
						end else begin
							// code already decoded or unit ignored: byte is dropped
							state_d = nal_in.last_byte ? nis_pkg::SQ_PAD : nis_pkg::SQ_IDLE;
						end
					end
				end
			end
			nis_pkg::SQ_BITS: begin
				if (parsing) begin
					ctl.step      = 1'b1;
					ctl.bit_val   = shift_q[nis_pkg::BYTE_W-2];
					ctl.final_bit = last_q && (cnt_q == '0);
					shift_d       = {shift_q[nis_pkg::BYTE_W-3:0], 1'b0};
					cnt_d         = cnt_q - 3'd1;
					if (cnt_q == '0) begin
						state_d = last_q ? nis_pkg::SQ_PAD : nis_pkg::SQ_IDLE;
					end
				end else begin
					state_d = last_q ? nis_pkg::SQ_PAD : nis_pkg::SQ_IDLE;
				end
			end
			nis_pkg::SQ_PAD: begin
				// bits past the end read as zero and close any open prefix
				if (parsing) begin
					ctl.step      = 1'b1;
					ctl.bit_val   = 1'b0;
					ctl.final_bit = 1'b1;
				end else begin
					state_d = nis_pkg::SQ_FINISH;
				end
			end
			nis_pkg::SQ_FINISH: begin
				if (!out_valid_q || result.ready) begin
					load_out     = 1'b1;
					ctl.clear    = 1'b1;
					byte_count_d = '0;
					state_d      = nis_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = nis_pkg::SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= nis_pkg::SQ_IDLE;
			cnt_q        <= '0;
			last_q       <= 1'b0;
			byte_count_q <= '0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			last_q       <= last_d;
			byte_count_q <= byte_count_d;
		end
	end

	always_ff @(posedge clk) begin
		shift_q <= shift_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_type_q  <= ust.header_type;
			out_intra_q <= res_intra;
			out_kind_q  <= res_kind;
			out_ovf_q   <= res_ovf;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.unit_type       = out_type_q;
	assign result.is_intra        = out_intra_q;
	assign result.slice_kind      = out_kind_q;
	assign result.prefix_overflow = out_ovf_q;

	// parser is back to expecting a header once a result is loaded
	a_clear_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (ust.phase == nis_pkg::PH_HEADER))
		else $error("parser not cleared after result load");

	// an overflowed unit never reports an intra slice or a slice kind
	a_ovf_not_intra: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.prefix_overflow) |-> (!result.is_intra && result.slice_kind == '0))
		else $error("overflow reported together with intra result");

	// once a header is taken the byte count is never zero
	a_count_with_header: assert property (@(posedge clk) disable iff (!arst_n)
		(ust.phase != nis_pkg::PH_HEADER) |-> (byte_count_q != '0))
		else $error("byte count lost while parsing a unit");

endmodule

>>> rtl/core/nis_bit_unit.sv
module nis_bit_unit #(
	parameter int MAX_PREFIX_ZEROS = nis_pkg::MAX_PREFIX_ZEROS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nis_pkg::nis_ctl_t ctl,
	output nis_pkg::nis_stat_t stat
);

	localparam int ZW = $clog2(MAX_PREFIX_ZEROS + 1);

	nis_pkg::nis_phase_t               phase_q, phase_d;
	logic [nis_pkg::TYPE_W-1:0]        header_q, header_d;
	logic [ZW-1:0]                     zero_run_q, zero_run_d;
	logic [ZW-1:0]                     suffix_left_q, suffix_left_d;
	logic [nis_pkg::CODE_W-1:0]        code_q, code_d;
	logic [2:0]                        res_q, res_d;
	logic [2:0]                        pw_q, pw_d;
	logic                              ovf_q, ovf_d;
	logic                              intra_q, intra_d;

	logic                              do_finish;
	nis_pkg::nis_phase_t               fin_phase;
	logic [nis_pkg::CODE_W-1:0]        fin_code;
	logic [2:0]                        fin_res;
	logic [ZW-1:0]                     sl_next;
	logic [2:0]                        m;

	always_comb begin
		phase_d       = phase_q;
		header_d      = header_q;
		zero_run_d    = zero_run_q;
		suffix_left_d = suffix_left_q;
		code_d        = code_q;
		res_d         = res_q;
		pw_d          = pw_q;
		ovf_d         = ovf_q;
		intra_d       = intra_q;
		do_finish     = 1'b0;
		fin_phase     = phase_q;
		fin_code      = code_q;
		fin_res       = res_q;
		sl_next       = suffix_left_q;
		m             = '0;

		if (ctl.clear) begin
			phase_d       = nis_pkg::PH_HEADER;
			header_d      = '0;
			zero_run_d    = '0;
			suffix_left_d = '0;
			code_d        = '0;
			res_d         = '0;
			pw_d          = 3'd1;
			ovf_d         = 1'b0;
			intra_d       = 1'b0;
		end else if (ctl.load_header) begin
			header_d = ctl.header_byte[nis_pkg::TYPE_W-1:0];
			phase_d  = (ctl.header_byte[nis_pkg::TYPE_W-1:0] == nis_pkg::TYPE_SLICE) ?
				nis_pkg::PH_MB_PREFIX : nis_pkg::PH_IGNORE;
		end else if (ctl.step) begin
			unique case (phase_q)
				nis_pkg::PH_MB_PREFIX, nis_pkg::PH_ST_PREFIX: begin
					if (ctl.bit_val || ctl.final_bit) begin
						// prefix closed: suffix of zero_run bits follows
						fin_phase     = (phase_q == nis_pkg::PH_MB_PREFIX) ?
							nis_pkg::PH_MB_SUFFIX : nis_pkg::PH_ST_SUFFIX;
						phase_d       = fin_phase;
						code_d        = '0;
						res_d         = '0;
						suffix_left_d = zero_run_q;
						fin_code      = '0;
						fin_res       = '0;
						do_finish     = (zero_run_q == '0);
					end else if (zero_run_q >= ZW'(MAX_PREFIX_ZEROS)) begin
						ovf_d   = 1'b1;
						phase_d = nis_pkg::PH_IGNORE;
					end else begin
						zero_run_d = zero_run_q + ZW'(1);
						pw_d       = nis_pkg::mod5_small({pw_q, 1'b0});
					end
				end
				nis_pkg::PH_MB_SUFFIX, nis_pkg::PH_ST_SUFFIX: begin
					fin_phase     = phase_q;
					fin_code      = {code_q[nis_pkg::CODE_W-2:0], ctl.bit_val};
					fin_res       = nis_pkg::mod5_small({res_q, ctl.bit_val});
					sl_next       = (suffix_left_q == '0) ? '0 : suffix_left_q - ZW'(1);
					code_d        = fin_code;
					res_d         = fin_res;
					suffix_left_d = sl_next;
					do_finish     = (sl_next == '0);
				end
				default: begin
				end
			endcase

			if (do_finish) begin
				suffix_left_d = '0;
				if (fin_phase == nis_pkg::PH_MB_SUFFIX) begin
					// macroblock address code done, start on slice_type
					phase_d    = nis_pkg::PH_ST_PREFIX;
					zero_run_d = '0;
					code_d     = '0;
					res_d      = '0;
					pw_d       = 3'd1;
				end else begin
					// value = suffix + 2^zero_run - 1
					code_d  = fin_code + ~({nis_pkg::CODE_W{1'b1}} << zero_run_q);
					m       = nis_pkg::mod5_small({1'b0, fin_res} + {1'b0, pw_q} + 4'd4);
					intra_d = (m == nis_pkg::KIND_I) || (m == nis_pkg::KIND_SI);
					phase_d = nis_pkg::PH_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= nis_pkg::PH_HEADER;
			header_q      <= '0;
			zero_run_q    <= '0;
			suffix_left_q <= '0;
			code_q        <= '0;
			res_q         <= '0;
			pw_q          <= 3'd1;
			ovf_q         <= 1'b0;
			intra_q       <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			header_q      <= header_d;
			zero_run_q    <= zero_run_d;
			suffix_left_q <= suffix_left_d;
			code_q        <= code_d;
			res_q         <= res_d;
			pw_q          <= pw_d;
			ovf_q         <= ovf_d;
			intra_q       <= intra_d;
		end
	end

	assign stat.phase       = phase_q;
	assign stat.header_type = header_q;
	assign stat.overflow    = ovf_q;
	assign stat.slice_intra = intra_q;
	assign stat.code_value  = code_q;

endmodule

>>> test/tb_nal_intra_slice_detector.sv
`timescale 1ns / 100ps

module tb_nal_intra_slice_detector;

	// prefix limit shared by the block and the local slice-header decoder
	localparam int MAX_ZEROS = nis_pkg::MAX_PREFIX_ZEROS_DEF;

	// one byte of a nal unit as the driver presents it
	typedef struct packed {
		logic [nis_pkg::BYTE_W-1:0] data;
		logic                       last;
	} nal_byte_t;

	// one verdict per nal unit, same fields as the result channel
	typedef struct packed {
		logic [nis_pkg::TYPE_W-1:0] unit_type;
		logic                       is_intra;
		logic [nis_pkg::CODE_W-1:0] slice_kind;
		logic                       prefix_overflow;
	} verdict_t;

	// idle plans, switched by how far the byte stream has got
	typedef enum logic [1:0] {
		PLAN_SLOW_SENDER,
		PLAN_SLOW_RECEIVER,
		PLAN_NO_IDLE
	} idle_plan_t;

	logic clk = 1'b0;
	logic arst_n;

	nis_in_if  nal_in();
	nis_out_if result();

	nal_intra_slice_detector #(
		.MAX_PREFIX_ZEROS(MAX_ZEROS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.nal_in(nal_in),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	nal_byte_t   pending_bytes[$];
	verdict_t    expected_verdicts[$];
	bit          payload_bits[$];
	nal_byte_t   issue_byte;
	int unsigned total_bytes;
	int unsigned bytes_taken;
	int unsigned mismatch_count;

	// slice-header decoder state, cleared after every unit
	nis_pkg::nis_phase_t        hdr_phase;
	logic [nis_pkg::TYPE_W-1:0] hdr_type;
	int unsigned                hdr_bytes;
	int unsigned                hdr_zeros;
	int unsigned                hdr_suffix_left;
	logic [nis_pkg::CODE_W-1:0] hdr_code;
	logic                       hdr_overflow;

	function automatic void clear_decoder();
		hdr_phase       = nis_pkg::PH_HEADER;
		hdr_type        = '0;
		hdr_bytes       = 0;
		hdr_zeros       = 0;
		hdr_suffix_left = 0;
		hdr_code        = '0;
		hdr_overflow    = 1'b0;
	endfunction

	function automatic bit in_prefix();
		return hdr_phase == nis_pkg::PH_MB_PREFIX || hdr_phase == nis_pkg::PH_ST_PREFIX;
	endfunction

	function automatic bit in_suffix();
		return hdr_phase == nis_pkg::PH_MB_SUFFIX || hdr_phase == nis_pkg::PH_ST_SUFFIX;
	endfunction

	// all suffix bits are in: the macroblock address code is dropped,
	// slice_type is kept
	function automatic void close_code();
		logic [63:0] sum;
		sum = 64'(hdr_code) + (64'd1 << (hdr_zeros & 31)) - 64'd1;
		if (hdr_phase == nis_pkg::PH_MB_SUFFIX) begin
			hdr_phase = nis_pkg::PH_ST_PREFIX;
			hdr_zeros = 0;
			hdr_suffix_left = 0;
			hdr_code = '0;
		end else begin
			hdr_code = sum[nis_pkg::CODE_W-1:0];
			hdr_suffix_left = 0;
			hdr_phase = nis_pkg::PH_DONE;
		end
	endfunction

	function automatic void open_suffix();
		hdr_phase = nis_pkg::nis_phase_t'(hdr_phase + 3'd1);
		hdr_code = '0;
		hdr_suffix_left = hdr_zeros;
		if (hdr_zeros == 0)
			close_code();
	endfunction

	function automatic void shift_suffix(input logic b);
		hdr_code = {hdr_code[nis_pkg::CODE_W-2:0], b};
		if (hdr_suffix_left > 0)
			hdr_suffix_left--;
		if (hdr_suffix_left == 0)
			close_code();
	endfunction

	function automatic void take_bit(input logic b, input logic final_bit);
		if (in_prefix()) begin
			// a zero in the unit's last bit position ends the prefix uncounted
			if (b || final_bit) begin
				open_suffix();
			end else if (hdr_zeros >= MAX_ZEROS) begin
				hdr_overflow = 1'b1;
				hdr_phase = nis_pkg::PH_IGNORE;
			end else begin
				hdr_zeros++;
			end
		end else if (in_suffix()) begin
			shift_suffix(b);
		end
	endfunction

	// feed one accepted byte; on the last byte of a unit queue its verdict
	function automatic void decode_nal_byte(input logic [nis_pkg::BYTE_W-1:0] b,
		input logic last);
		verdict_t v;
		if (hdr_phase == nis_pkg::PH_HEADER) begin
			hdr_type = b[nis_pkg::TYPE_W-1:0];
			hdr_bytes = 1;
			hdr_phase = (hdr_type == nis_pkg::TYPE_SLICE) ?
				nis_pkg::PH_MB_PREFIX : nis_pkg::PH_IGNORE;
		end else begin
			if (hdr_bytes < nis_pkg::BYTE_COUNT_FULL)
				hdr_bytes++;
			for (int i = 7; i >= 0; i--)
				take_bit(b[i], last && i == 0);
		end
		if (!last)
			return;
		v = '0;
		v.unit_type = hdr_type;
		if (hdr_bytes >= nis_pkg::BYTE_COUNT_FULL) begin
			if (hdr_type == nis_pkg::TYPE_IDR) begin
				v.is_intra = 1'b1;
			end else if (hdr_type == nis_pkg::TYPE_SLICE) begin
				if (hdr_overflow) begin
					v.prefix_overflow = 1'b1;
				end else begin
					// bits past the end read as zero
					for (int g = 0; g < 200 && (in_prefix() || in_suffix()); g++) begin
						if (in_prefix())
							open_suffix();
						else
							shift_suffix(1'b0);
					end
					if (hdr_phase == nis_pkg::PH_DONE)
						v.slice_kind = hdr_code;
					v.is_intra = (v.slice_kind % 5 == nis_pkg::KIND_I) ||
						(v.slice_kind % 5 == nis_pkg::KIND_SI);
				end
			end
		end
		expected_verdicts.push_back(v);
		clear_decoder();
	endfunction

	// directed units, bytes packed first byte highest
	function automatic void queue_bytes(input logic [63:0] packed_bytes, input int n);
		for (int i = 0; i < n; i++)
			pending_bytes.push_back('{packed_bytes[8*(n-1-i) +: 8], i == n - 1});
	endfunction

	// mostly short codes so slice types spread over all residues, some deep
	// prefixes and a few past the overflow limit
	function automatic int unsigned pick_prefix_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 3);
		else if (r < 88)
			return $urandom_range(4, 27);
		return $urandom_range(28, 34);
	endfunction

	function automatic void add_ue(input int unsigned n, input logic [31:0] suffix);
		repeat (n) payload_bits.push_back(1'b0);
		payload_bits.push_back(1'b1);
		for (int i = int'(n) - 1; i >= 0; i--)
			payload_bits.push_back((i < 32) ? suffix[i[4:0]] : 1'b0);
	endfunction

	function automatic void add_noise_bits(input int unsigned n);
		repeat (n) payload_bits.push_back(1'($urandom_range(0, 1)));
	endfunction

	// header byte followed by the payload bits packed msb first
	function automatic void queue_payload_unit(input logic [nis_pkg::BYTE_W-1:0] hdr,
		input bit zero_fill);
		int unsigned n;
		logic [nis_pkg::BYTE_W-1:0] b;
		while (payload_bits.size() % 8 != 0)
			payload_bits.push_back(zero_fill ? 1'b0 : 1'($urandom_range(0, 1)));
		n = payload_bits.size() / 8;
		pending_bytes.push_back('{hdr, n == 0});
		for (int k = 0; k < int'(n); k++) begin
			for (int j = 0; j < 8; j++)
				b[7-j] = payload_bits[8*k+j];
			pending_bytes.push_back('{b, k == int'(n) - 1});
		end
	endfunction

	function automatic void build_stimulus();
		int unsigned r;
		int unsigned keep;
		bit cut;
		logic [nis_pkg::BYTE_W-1:0] hdr;

		// short units, idr, i slice, final zero bit closing a prefix,
		// long prefix, ignored type, p slice, si slice, zero header
		queue_bytes(64'h65, 1);
		queue_bytes(64'h65_88, 2);
		queue_bytes(64'h65_88_84, 3);
		queue_bytes(64'h41_88_80, 3);
		queue_bytes(64'h01_80_00, 3);
		queue_bytes(64'h01_00_00_00_00_ff, 6);
		queue_bytes(64'hff_ff_ff, 3);
		queue_bytes(64'he1_ff_00, 3);
		queue_bytes(64'h41_8a_00, 3);
		queue_bytes(64'h00_ff, 2);

		while (pending_bytes.size() < 925) begin
			r = $urandom_range(0, 99);
			payload_bits.delete();
			hdr = 8'($urandom());
			cut = 1'b0;
			if (r < 60) begin
				// well-formed slice header with random codes and tail
				hdr[nis_pkg::TYPE_W-1:0] = nis_pkg::TYPE_SLICE;
				add_ue(pick_prefix_len(), $urandom());
				add_ue(pick_prefix_len(), $urandom());
				add_noise_bits($urandom_range(0, 16));
				// sometimes end the unit inside a code
				cut = ($urandom_range(0, 3) == 0);
				if (cut) begin
					keep = $urandom_range(0, payload_bits.size());
					while (payload_bits.size() > keep)
						void'(payload_bits.pop_back());
				end
			end else if (r < 75) begin
				hdr[nis_pkg::TYPE_W-1:0] = $urandom_range(0, 1) ? nis_pkg::TYPE_IDR :
					nis_pkg::TYPE_W'($urandom_range(0, 31));
				add_noise_bits($urandom_range(0, 40));
			end else if (r < 85) begin
				hdr[nis_pkg::TYPE_W-1:0] = nis_pkg::TYPE_SLICE;
				add_noise_bits($urandom_range(0, 48));
			end else begin
				add_noise_bits($urandom_range(0, 64));
			end
			queue_payload_unit(hdr, cut);
		end
	endfunction

	function automatic idle_plan_t current_plan();
		if (bytes_taken * 3 < total_bytes)
			return PLAN_SLOW_RECEIVER;
		else if (bytes_taken * 3 < total_bytes * 2)
			return PLAN_SLOW_SENDER;
		return PLAN_NO_IDLE;
	endfunction

	// first third: sender idles 19 of 100, receiver 73; then swapped; then none
	function automatic int unsigned sender_idle_pct();
		unique case (current_plan())
			PLAN_SLOW_RECEIVER: return 19;
			PLAN_SLOW_SENDER:   return 73;
			default:            return 0;
		endcase
	endfunction

	function automatic int unsigned receiver_idle_pct();
		unique case (current_plan())
			PLAN_SLOW_RECEIVER: return 73;
			PLAN_SLOW_SENDER:   return 19;
			default:            return 0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// byte driver: accepted bytes go straight into the decoder, then the
	// next pending byte is offered unless this cycle idles
	always @(posedge clk) begin
		if (!arst_n) begin
			nal_in.valid <= 1'b0;
		end else begin
			if (nal_in.valid && nal_in.ready) begin
				decode_nal_byte(nal_in.data_byte, nal_in.last_byte);
				bytes_taken++;
			end
			if (!nal_in.valid || nal_in.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					issue_byte = pending_bytes.pop_front();
					nal_in.valid     <= 1'b1;
					nal_in.data_byte <= issue_byte.data;
					nal_in.last_byte <= issue_byte.last;
				end else begin
					nal_in.valid <= 1'b0;
				end
			end
		end
	end

	// verdict monitor: each accepted result against the oldest expected one
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("verdict with none expected, unit_type",
						32'(result.unit_type), 32'd0);
				end else begin
					check_field("unit_type", 32'(result.unit_type),
						32'(expected_verdicts[0].unit_type));
					check_field("is_intra", 32'(result.is_intra),
						32'(expected_verdicts[0].is_intra));
					check_field("slice_kind", result.slice_kind,
						expected_verdicts[0].slice_kind);
					check_field("prefix_overflow", 32'(result.prefix_overflow),
						32'(expected_verdicts[0].prefix_overflow));
					void'(expected_verdicts.pop_front());
				end
			end
			result.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	initial begin
		arst_n           = 1'b0;
		nal_in.valid     = 1'b0;
		nal_in.data_byte = '0;
		nal_in.last_byte = 1'b0;
		result.ready     = 1'b0;
		bytes_taken      = 0;
		mismatch_count   = 0;
		clear_decoder();
		build_stimulus();
		total_bytes = pending_bytes.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// every byte taken, then every verdict seen
		while (pending_bytes.size() != 0 || nal_in.valid)
			@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		// room for a late extra verdict: longest padding pass plus a byte
		repeat (64) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_nal_intra_slice_detector passed");
		else
			$display("tb_nal_intra_slice_detector failed");
		$finish;
	end

	// time limit far beyond the slowest legal run
	initial begin
		#2000000;
		$display("tb_nal_intra_slice_detector failed");
		$finish;
	end

endmodule
